/* rtl/set_assoc_cache_lru_sim_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache tag model
// Short forms for clocked implications with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SCAC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SCAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

/* rtl/scac_pkg.sv */
// ----------------------------------------------------------------------------
// scac_pkg
// Shared constants, codes and control types of the cache tag model.
// ----------------------------------------------------------------------------
package scac_pkg;

   localparam int DEF_MAX_SET_BITS = 4;
   localparam int DEF_MAX_WAYS     = 16;
   localparam int DEF_ADDR_WIDTH   = 48;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int SHIFT_W    = 7;
   localparam int COUNT_W    = 32;
   localparam int AGE_W      = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd2;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_FETCH  = 2'd3;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   typedef struct packed {
      logic capture;
      logic read;
      logic evaluate;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic is_fetch;
   } status_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + COUNT_W'(1);
   endfunction

endpackage

/* rtl/scac_ctrl.sv */
// ----------------------------------------------------------------------------
// scac_ctrl
// Sequencer: accept, set read, evaluate, write back and result hand-off.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_sim_macros.svh"

module scac_ctrl import scac_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_EVAL  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            // drop instruction fetches without touching the store
            if (status.is_fetch) begin
               state_in = ST_IDLE;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.evaluate = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SCAC_ASSERT_NEXT(a_accept_reads, clock, reset, req_valid && !req_stall, state_ff == ST_READ)
   `SCAC_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_valid_ff)
   `SCAC_ASSERT_NEXT(a_pending_holds, clock, reset,
                     state_ff == ST_WRITE && rsp_valid_ff && rsp_stall, state_ff == ST_WRITE)

endmodule

/* rtl/scac_dp.sv */
// ----------------------------------------------------------------------------
// scac_dp
// Datapath: configuration, set store, tag compare, LRU victim tree, totals.
// ----------------------------------------------------------------------------
module scac_dp import scac_pkg::*; #(
   parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = DEF_MAX_WAYS,
   parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [1:0]            req_operation,
   input  logic [ADDR_WIDTH-1:0] req_address,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [1:0]            rsp_outcome,
   output logic                  rsp_modify_hit,
   output logic [COUNT_W-1:0]    rsp_total_hits,
   output logic [COUNT_W-1:0]    rsp_total_misses,
   output logic [COUNT_W-1:0]    rsp_total_evictions
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int PAD      = 1 << WAY_W;
   localparam int WCNT_W   = WAY_W + 1;

   // configuration
   logic [2:0]            sbits_cfg_ff;
   logic [4:0]            ways_cfg_ff;
   logic [4:0]            bbits_cfg_ff;

   // access
   logic [1:0]            op_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;

   // set store
   logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_mem [NUM_SETS];
   logic [MAX_WAYS*AGE_W-1:0]      age_mem [NUM_SETS];
   logic [MAX_WAYS-1:0]            valid_ff [NUM_SETS];
   logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_row_ff;
   logic [MAX_WAYS*AGE_W-1:0]      age_row_ff;
   logic [MAX_WAYS-1:0]            valid_row_ff;

   // evaluation
   logic             hit_ff, hit_in, empty_ff, empty_in;
   logic [WAY_W-1:0] hit_way_ff, hit_way_in, victim_ff, victim_in;

   logic [COUNT_W-1:0] hits_ff, misses_ff, evicts_ff;
   logic [1:0]         outcome_ff;
   logic               modify_ff;

   logic [SHIFT_W-1:0]            sbits_eff, shift_tag;
   logic [WCNT_W-1:0]             ways_eff;
   logic [ADDR_WIDTH-1:0]         tag_now, set_shift;
   logic [MAX_SET_BITS-1:0]       set_idx;
   logic [MAX_WAYS-1:0]           way_used;
   logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_row_in;
   logic [MAX_WAYS*AGE_W-1:0]     age_row_in;
   logic [MAX_WAYS-1:0]           valid_row_in;
   logic [WAY_W-1:0]              target;
   logic [COUNT_W-1:0]            hits_one;

   logic             node_ok  [WAY_W+1][PAD];
   logic [AGE_W-1:0] node_age [WAY_W+1][PAD];
   logic [WAY_W-1:0] node_idx [WAY_W+1][PAD];

   assign status.is_fetch = (op_ff == OP_FETCH);

   always_comb begin
      sbits_eff = (SHIFT_W'(sbits_cfg_ff) > SHIFT_W'(MAX_SET_BITS)) ?
                  SHIFT_W'(MAX_SET_BITS) : SHIFT_W'(sbits_cfg_ff);
      if (ways_cfg_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (32'(ways_cfg_ff) > 32'(MAX_WAYS)) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_cfg_ff);
      end
      shift_tag = sbits_eff + SHIFT_W'(bbits_cfg_ff);
      tag_now   = addr_ff >> shift_tag;
      set_shift = addr_ff >> bbits_cfg_ff;
      for (int i = 0; i < MAX_SET_BITS; i++) begin
         set_idx[i] = set_shift[i] && (SHIFT_W'(i) < sbits_eff);
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_used[w] = (WCNT_W'(w) < ways_eff);
      end
   end

   // first matching way and first empty way
   always_comb begin
      hit_in     = 1'b0;
      hit_way_in = '0;
      empty_in   = 1'b0;
      victim_in  = node_idx[WAY_W][0];
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (way_used[w] && valid_row_ff[w] &&
             tag_row_ff[w*ADDR_WIDTH +: ADDR_WIDTH] == tag_now) begin
            hit_in     = 1'b1;
            hit_way_in = WAY_W'(w);
         end
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (way_used[w] && !valid_row_ff[w]) begin
            empty_in  = 1'b1;
            victim_in = WAY_W'(w);
         end
      end
   end

   // oldest way; the lower way wins a tie
   always_comb begin
      for (int w = 0; w < PAD; w++) begin
         node_idx[0][w] = WAY_W'(w);
         if (w < MAX_WAYS) begin
            node_ok[0][w]  = way_used[w];
            node_age[0][w] = age_row_ff[w*AGE_W +: AGE_W];
         end else begin
            node_ok[0][w]  = 1'b0;
            node_age[0][w] = '0;
         end
      end
      for (int l = 0; l < WAY_W; l++) begin
         for (int n = 0; n < PAD; n++) begin
            node_ok[l+1][n]  = 1'b0;
            node_age[l+1][n] = '0;
            node_idx[l+1][n] = '0;
            if (n < (PAD >> (l + 1))) begin
               if (node_ok[l][2*n+1] &&
                   (!node_ok[l][2*n] || node_age[l][2*n+1] > node_age[l][2*n])) begin
                  node_ok[l+1][n]  = 1'b1;
                  node_age[l+1][n] = node_age[l][2*n+1];
                  node_idx[l+1][n] = node_idx[l][2*n+1];
               end else begin
                  node_ok[l+1][n]  = node_ok[l][2*n];
                  node_age[l+1][n] = node_age[l][2*n];
                  node_idx[l+1][n] = node_idx[l][2*n];
               end
            end
         end
      end
   end

   // updated row
   always_comb begin
      target       = hit_ff ? hit_way_ff : victim_ff;
      tag_row_in   = tag_row_ff;
      age_row_in   = age_row_ff;
      valid_row_in = valid_row_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (way_used[w]) begin
            if (WAY_W'(w) == target) begin
               tag_row_in[w*ADDR_WIDTH +: ADDR_WIDTH] = tag_now;
               age_row_in[w*AGE_W +: AGE_W]           = '0;
               valid_row_in[w]                        = 1'b1;
            end else if (valid_row_ff[w]) begin
               age_row_in[w*AGE_W +: AGE_W] = sat_inc(age_row_ff[w*AGE_W +: AGE_W]);
            end
         end
      end
      hits_one = hit_ff ? sat_inc(hits_ff) : hits_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbits_cfg_ff <= 3'd1;
         ways_cfg_ff  <= 5'd1;
         bbits_cfg_ff <= 5'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SET_BITS:    sbits_cfg_ff <= csr_data[2:0];
            CSR_WAYS:        ways_cfg_ff  <= csr_data;
            CSR_OFFSET_BITS: bbits_cfg_ff <= csr_data;
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         addr_ff <= req_address;
      end
      if (cmd.read) begin
         tag_row_ff   <= tag_mem[set_idx];
         age_row_ff   <= age_mem[set_idx];
         valid_row_ff <= valid_ff[set_idx];
      end
      if (cmd.evaluate) begin
         hit_ff     <= hit_in;
         hit_way_ff <= hit_way_in;
         empty_ff   <= empty_in;
         victim_ff  <= victim_in;
      end
      if (cmd.commit) begin
         tag_mem[set_idx] <= tag_row_in;
         age_mem[set_idx] <= age_row_in;
         outcome_ff       <= hit_ff ? OUT_HIT : (empty_ff ? OUT_FILL : OUT_EVICT);
         modify_ff        <= (op_ff == OP_MODIFY);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s] <= '0;
         end
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[set_idx] <= valid_row_in;
         hits_ff <= (op_ff == OP_MODIFY) ? sat_inc(hits_one) : hits_one;
         if (!hit_ff) begin
            misses_ff <= sat_inc(misses_ff);
            if (!empty_ff) begin
               evicts_ff <= sat_inc(evicts_ff);
            end
         end
      end
   end

   assign rsp_outcome         = outcome_ff;
   assign rsp_modify_hit      = modify_ff;
   assign rsp_total_hits      = hits_ff;
   assign rsp_total_misses    = misses_ff;
   assign rsp_total_evictions = evicts_ff;

endmodule

/* rtl/set_assoc_cache_lru_sim.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Tag-only set-associative cache model with LRU replacement and totals.
// ----------------------------------------------------------------------------
// The block runs one access at a time and stalls its input until the
// access is done. Its steps are:
//  - take the beat,
//  - read the set's row from the tag/age store,
//  - compare all ways and pick the oldest way through a
//    compare tree,
//  - write the row back and load the result.
// The result is registered with the write-back. A result beat
// that is stalled holds the write-back of the next access, and the input
// stays stalled until that beat is taken. A fetch is dropped in the read step
// and gives no result. Valid bits clear at reset, so no clearing pass is
// needed. Totals saturate at all ones.
module set_assoc_cache_lru_sim import scac_pkg::*; #(
   parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = DEF_MAX_WAYS,
   parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_operation,
   input  logic [ADDR_WIDTH-1:0] req_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_outcome,
   output logic                  rsp_modify_hit,
   output logic [COUNT_W-1:0]    rsp_total_hits,
   output logic [COUNT_W-1:0]    rsp_total_misses,
   output logic [COUNT_W-1:0]    rsp_total_evictions
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   scac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scac_dp #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS),
      .ADDR_WIDTH   (ADDR_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_operation       (req_operation),
      .req_address         (req_address),
      .cmd                 (cmd),
      .status              (status),
      .rsp_outcome         (rsp_outcome),
      .rsp_modify_hit      (rsp_modify_hit),
      .rsp_total_hits      (rsp_total_hits),
      .rsp_total_misses    (rsp_total_misses),
      .rsp_total_evictions (rsp_total_evictions)
   );

endmodule

/* test/tb_set_assoc_cache_lru_sim.sv */
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_sim
// Checks the cache tag model against an LRU tag predictor. Runs directed
// accesses, then random ones under several geometries. Both sides idle
// and stall at random, and the result side holds off once for a long time.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_sim;
   import scac_pkg::*;

   localparam int SETS        = 1 << DEF_MAX_SET_BITS;
   localparam int WAYS        = DEF_MAX_WAYS;
   localparam int CYCLE_LIMIT = 900000;

   typedef struct {
      logic [1:0]  outcome;
      logic        modify_hit;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evictions;
   } cache_result_type;

   class lru_tag_predictor;
      bit [2:0]         set_bits_reg;
      bit [4:0]         ways_reg;
      bit [4:0]         offset_reg;
      bit               line_valid [SETS*WAYS];
      bit [47:0]        line_tag [SETS*WAYS];
      bit [31:0]        line_age [SETS*WAYS];
      bit [31:0]        hit_total;
      bit [31:0]        miss_total;
      bit [31:0]        evict_total;
      cache_result_type pending_results[$];
      int               errors;

      function new();
         set_bits_reg = 1;
         ways_reg = 1;
         offset_reg = 1;
         foreach (line_valid[i]) begin
            line_valid[i] = 0;
            line_tag[i] = '0;
            line_age[i] = '0;
         end
         hit_total = 0;
         miss_total = 0;
         evict_total = 0;
         errors = 0;
      endfunction

      function int eff_set_bits();
         return (set_bits_reg > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : set_bits_reg;
      endfunction

      function int eff_ways();
         return (ways_reg == 0) ? 1 : ((ways_reg > WAYS) ? WAYS : ways_reg);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SET_BITS: set_bits_reg = data[2:0];
            CSR_WAYS: ways_reg = data;
            CSR_OFFSET_BITS: offset_reg = data;
            default: ;
         endcase
      endfunction

      function bit [31:0] sat_up(bit [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 1;
      endfunction

      function void age_others(int base, int ways, int keep);
         for (int w = 0; w < ways; w++)
            if (w != keep && line_valid[base+w])
               line_age[base+w] = sat_up(line_age[base+w]);
      endfunction

      function void note_access(logic [1:0] op, logic [47:0] addr);
         int               sbits;
         int               ways;
         int               base;
         int               victim;
         bit               found;
         bit               empty;
         bit [31:0]        oldest;
         bit [63:0]        set_no;
         bit [47:0]        tag;
         cache_result_type r;
         if (op == OP_FETCH) return;
         sbits = eff_set_bits();
         ways = eff_ways();
         set_no = ({16'h0, addr} >> offset_reg) & ((64'd1 << sbits) - 1);
         tag = 48'({16'h0, addr} >> (sbits + offset_reg));
         base = int'(set_no) * WAYS;
         found = 0;
         r.outcome = OUT_HIT;
         for (int w = 0; w < ways && !found; w++) begin
            if (line_valid[base+w] && line_tag[base+w] == tag) begin
               line_age[base+w] = 0;
               age_others(base, ways, w);
               found = 1;
            end
         end
         if (found) begin
            hit_total = sat_up(hit_total);
         end else begin
            empty = 0;
            oldest = 0;
            victim = 0;
            for (int w = 0; w < ways && !empty; w++) begin
               if (!line_valid[base+w]) begin
                  victim = w;
                  empty = 1;
               end else if (w == 0 || line_age[base+w] > oldest) begin
                  oldest = line_age[base+w];
                  victim = w;
               end
            end
            age_others(base, ways, victim);
            line_tag[base+victim] = tag;
            line_age[base+victim] = 0;
            line_valid[base+victim] = 1;
            miss_total = sat_up(miss_total);
            if (empty) begin
               r.outcome = OUT_FILL;
            end else begin
               r.outcome = OUT_EVICT;
               evict_total = sat_up(evict_total);
            end
         end
         if (op == OP_MODIFY) hit_total = sat_up(hit_total);
         r.modify_hit = (op == OP_MODIFY);
         r.hits = hit_total;
         r.misses = miss_total;
         r.evictions = evict_total;
         pending_results.push_back(r);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(cache_result_type got);
         cache_result_type want;
         if (pending_results.size() == 0) begin
            report("result beat with nothing expected");
            return;
         end
         want = pending_results.pop_front();
         if (got.outcome !== want.outcome)
            report($sformatf("outcome %0d, want %0d", got.outcome, want.outcome));
         if (got.modify_hit !== want.modify_hit)
            report($sformatf("modify_hit %0b, want %0b", got.modify_hit, want.modify_hit));
         if (got.hits !== want.hits)
            report($sformatf("total_hits %0d, want %0d", got.hits, want.hits));
         if (got.misses !== want.misses)
            report($sformatf("total_misses %0d, want %0d", got.misses, want.misses));
         if (got.evictions !== want.evictions)
            report($sformatf("total_evictions %0d, want %0d", got.evictions, want.evictions));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_operation;
   logic [47:0]           req_address;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [1:0]            rsp_outcome;
   logic                  rsp_modify_hit;
   logic [COUNT_W-1:0]    rsp_total_hits;
   logic [COUNT_W-1:0]    rsp_total_misses;
   logic [COUNT_W-1:0]    rsp_total_evictions;

   lru_tag_predictor predictor = new();
   int  cycle_count = 0;
   int  results_seen = 0;
   bit  quiet_phase = 0;
   bit  held_off = 0;

   set_assoc_cache_lru_sim uut (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side: check each beat, then choose next cycle's stall
   always @(posedge clock) begin
      static int stall_left = 0;
      cache_result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.outcome = rsp_outcome;
            got.modify_hit = rsp_modify_hit;
            got.hits = rsp_total_hits;
            got.misses = rsp_total_misses;
            got.evictions = rsp_total_evictions;
            predictor.check_result(got);
            results_seen++;
         end
         if (!held_off && results_seen >= 150) begin
            held_off = 1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   task send_access(logic [1:0] op, logic [47:0] addr);
      int gap;
      req_valid <= 1'b1;
      req_operation <= op;
      req_address <= addr;
      do @(posedge clock); while (req_stall);
      predictor.note_access(op, addr);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      predictor.write_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   // let the last results drain, plus a wait so that a dropped fetch also ends
   task drain_block();
      req_valid <= 1'b0;
      while (predictor.pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task run_phase(logic [4:0] sb, logic [4:0] wy, logic [4:0] ob, int count);
      int          sbits;
      int          pool;
      int          r;
      int          sent;
      logic [1:0]  op;
      logic [63:0] addr;
      drain_block();
      write_csr(CSR_SET_BITS, sb);
      write_csr(CSR_WAYS, wy);
      write_csr(CSR_OFFSET_BITS, ob);
      sbits = predictor.eff_set_bits();
      pool = predictor.eff_ways() + $urandom_range(1, 3);
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(0, 99);
         op = (r < 10) ? OP_FETCH : 2'($urandom_range(0, 2));
         if ($urandom_range(0, 99) < 12) begin
            addr = {$urandom, $urandom};
         end else begin
            addr = 64'($urandom_range(0, pool - 1)) << (sbits + ob);
            addr |= (64'($urandom_range(0, SETS - 1)) & ((64'd1 << sbits) - 1)) << ob;
            addr |= {$urandom, $urandom} & ((64'd1 << ob) - 1);
         end
         send_access(op, addr[47:0]);
         sent++;
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= CSR_SET_BITS;
      csr_data <= '0;
      req_valid <= 1'b0;
      req_operation <= OP_LOAD;
      req_address <= '0;
      rsp_stall <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: two sets, one way, two-byte blocks
      send_access(OP_FETCH, 48'h0);
      send_access(OP_LOAD, 48'h0);
      send_access(OP_LOAD, 48'h0);
      send_access(OP_STORE, 48'h1);
      send_access(OP_MODIFY, 48'h0);
      send_access(OP_LOAD, 48'hFFFF_FFFF_FFFF);
      send_access(OP_STORE, 48'hFFFF_FFFF_FFFF);
      send_access(OP_LOAD, 48'h4);
      send_access(OP_MODIFY, 48'h0);
      send_access(OP_FETCH, 48'hFFFF_FFFF_FFFF);
      send_access(OP_LOAD, 48'h8000_0000_0000);
      send_access(OP_STORE, 48'h5555_5555_5555);
      send_access(OP_LOAD, 48'hAAAA_AAAA_AAAA);
      send_access(OP_MODIFY, 48'h0000_0000_0002);

      quiet_phase = 0;
      run_phase(5'd4, 5'd16, 5'd4, 200);
      quiet_phase = 1;
      run_phase(5'd0, 5'd1, 5'd0, 150);
      quiet_phase = 0;
      run_phase(5'd7, 5'd31, 5'd31, 170);
      run_phase(5'd2, 5'd4, 5'd5, 170);
      quiet_phase = 1;
      run_phase(5'd3, 5'd0, 5'd16, 150);
      quiet_phase = 0;
      run_phase(5'd1, 5'd8, 5'd2, 170);
      run_phase(5'd4, 5'd16, 5'd0, 170);
      run_phase(5'd12, 5'd2, 5'd9, 150);

      drain_block();
      if (predictor.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* set_assoc_cache_lru_sim.f */
+incdir+rtl
rtl/scac_pkg.sv
rtl/scac_ctrl.sv
rtl/scac_dp.sv
rtl/set_assoc_cache_lru_sim.sv
test/tb_set_assoc_cache_lru_sim.sv
